/* rtl/rgbyuyv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbyuyv_pkg
// Shared types and constants for the RGB888 to YUYV 4:2:2 packer.
// ----------------------------------------------------------------------------
package rgbyuyv_pkg;

    localparam int CHAN_W = 8;
    localparam int PCT_W  = 7;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [PCT_W-1:0]  t_pct;

    // floor(c*100/255) = (c*100*257 + 257) >> 16, exact for 8-bit c
    localparam int SCALE_MUL_W = 15;
    localparam int SCALE_PROD_W = 23;
    localparam logic [SCALE_MUL_W-1:0]  SCALE_MUL   = 15'd25700;
    localparam logic [SCALE_PROD_W-1:0] SCALE_RND   = 23'd257;
    localparam int                      SCALE_SHIFT = 16;

    // floor(209*s/300) = (s * 209 * 111849) >> 25, exact for s <= 300
    localparam int SUM_W       = 9;
    localparam int LUMA_MUL_W  = 25;
    localparam int LUMA_PROD_W = SUM_W + LUMA_MUL_W;
    localparam logic [LUMA_MUL_W-1:0] LUMA_MUL   = 25'd23376441;
    localparam int                    LUMA_SHIFT = 25;
    localparam t_chan                 LUMA_OFS   = 8'd16;
    localparam logic [SUM_W-1:0]      CHROMA_OFS = 9'd128;

endpackage

/* rtl/rgbyuyv_if.sv */
// ----------------------------------------------------------------------------
// rgbyuyv_pix_if / rgbyuyv_out_if
// Valid/ready channels for RGB pixel requests and packed YUYV results.
// ----------------------------------------------------------------------------
interface rgbyuyv_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rgbyuyv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] chroma;
    logic [7:0] luma;
    logic       last_out;

    modport source (output valid, chroma, luma, last_out, input ready);
    modport sink   (input valid, chroma, luma, last_out, output ready);
endinterface

/* rtl/rgbyuyv_percent.sv */
// ----------------------------------------------------------------------------
// rgbyuyv_percent
// Scales one 8-bit colour channel to 0..100 (c*100/255, truncating).
// ----------------------------------------------------------------------------
module rgbyuyv_percent (
    input  rgbyuyv_pkg::t_chan i_chan,
    output rgbyuyv_pkg::t_pct  o_pct
);
    import rgbyuyv_pkg::*;

    logic [SCALE_PROD_W-1:0] prod;

    assign prod  = SCALE_PROD_W'(i_chan) * SCALE_PROD_W'(SCALE_MUL) + SCALE_RND;
    assign o_pct = prod[SCALE_SHIFT +: PCT_W];

endmodule

/* rtl/rgb_to_yuyv_pixel_packer_unit.sv */
// ----------------------------------------------------------------------------
// rgb_to_yuyv_pixel_packer_unit
// RGB888 pixel stream to packed YUYV 4:2:2 halfwords, one result per pixel.
//
//   channel   modport  payload                        dir
//   i_pix     sink     red, green, blue, last_pixel   in
//   o_yuyv    source   chroma, luma, last_out         out
//
// Two register stages: channel scaling, then luma/chroma. One pixel per
// cycle sustained while o_yuyv.ready holds; each result passes both stages.
// Synchronous active-low reset empties both stages and resets the phase
// to even. A stall on o_yuyv fills the stages, then i_pix.ready drops.
// ----------------------------------------------------------------------------
module rgb_to_yuyv_pixel_packer_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rgbyuyv_pix_if.sink   i_pix,
    rgbyuyv_out_if.source o_yuyv
);
    import rgbyuyv_pkg::*;

    t_pct pct_r, pct_g, pct_b;

    logic r_s1_valid;
    t_pct r_s1_r, r_s1_g, r_s1_b;
    logic r_s1_last;
    logic r_s1_odd;
    logic r_odd;
    logic n_odd;

    logic  r_out_valid;
    t_chan r_chroma, r_luma;
    logic  r_last;

    logic s1_ready, s2_ready;
    logic pix_req;

    logic [SUM_W-1:0]       sum;
    logic [LUMA_PROD_W-1:0] luma_prod;
    logic [SUM_W-1:0]       g34, cb, cr;
    t_chan                  n_luma, n_chroma;

    rgbyuyv_percent u_pct_r (.i_chan(i_pix.red),   .o_pct(pct_r));
    rgbyuyv_percent u_pct_g (.i_chan(i_pix.green), .o_pct(pct_g));
    rgbyuyv_percent u_pct_b (.i_chan(i_pix.blue),  .o_pct(pct_b));

    assign s2_ready    = !r_out_valid || o_yuyv.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;
    assign pix_req     = i_pix.valid && s1_ready;
    assign n_odd       = i_pix.last_pixel ? 1'b0 : ~r_odd;

    always_comb begin
        sum       = SUM_W'(r_s1_r) + SUM_W'(r_s1_g) + SUM_W'(r_s1_b);
        luma_prod = LUMA_PROD_W'(sum) * LUMA_PROD_W'(LUMA_MUL);
        n_luma    = luma_prod[LUMA_SHIFT +: CHAN_W] + LUMA_OFS;
        g34       = (SUM_W'(r_s1_g) * SUM_W'(3)) >> 2;
        cb        = SUM_W'(r_s1_b) + CHROMA_OFS - (SUM_W'(r_s1_r) >> 2) - g34;
        cr        = SUM_W'(r_s1_r) + CHROMA_OFS - g34 - (SUM_W'(r_s1_b) >> 2);
        n_chroma  = r_s1_odd ? cr[CHAN_W-1:0] : cb[CHAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_odd       <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_pix.valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (pix_req) begin
                r_odd <= n_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_req) begin
            r_s1_r    <= pct_r;
            r_s1_g    <= pct_g;
            r_s1_b    <= pct_b;
            r_s1_last <= i_pix.last_pixel;
            r_s1_odd  <= r_odd;
        end
        if (s2_ready && r_s1_valid) begin
            r_chroma <= n_chroma;
            r_luma   <= n_luma;
            r_last   <= r_s1_last;
        end
    end

    assign o_yuyv.valid    = r_out_valid;
    assign o_yuyv.chroma   = r_chroma;
    assign o_yuyv.luma     = r_luma;
    assign o_yuyv.last_out = r_last;

endmodule
